>>> rtl/gbnfr_pkg.sv
// ----------------------------------------------------------------------------
// gbnfr_pkg
// Shared types and constants for the go-back-n frame receiver.
// ----------------------------------------------------------------------------
package gbnfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int WINDOW      = 8;

  localparam int POS_W = 7;

  // byte positions (0-based) that bound the frame layout
  localparam logic [POS_W-1:0] POS_SAT         = 7'd127;
  localparam logic [POS_W-1:0] POS_SEQ_HI      = 7'd1;
  localparam logic [POS_W-1:0] POS_SEQ_LO      = 7'd2;
  localparam logic [POS_W-1:0] POS_END_MARK    = 7'd3;
  localparam logic [POS_W-1:0] POS_ACK_COPY_LO = 7'd4;
  localparam logic [POS_W-1:0] POS_FIRST_PAY   = 7'd5;
  localparam logic [POS_W-1:0] POS_STREAM_LAST = POS_W'(MAX_PAYLOAD + 4);
  localparam logic [POS_W-1:0] POS_MAX_LAST    = POS_W'(MAX_PAYLOAD + 5);

  localparam logic [15:0] WINDOW_HI = 16'(WINDOW + 1);

  localparam logic [7:0] TYPE_DATA     = 8'd0;
  localparam logic [7:0] TYPE_ACK      = 8'd1;
  localparam logic [7:0] END_OF_PACKET = 8'd1;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_t;

  typedef enum logic [3:0] {
    VERD_PACKET_DONE  = 4'd0,
    VERD_FIRST_HELD   = 4'd1,
    VERD_DUPLICATE    = 4'd2,
    VERD_OUT_OF_WIN   = 4'd3,
    VERD_BAD_LENGTH   = 4'd4,
    VERD_BAD_CHECK    = 4'd5,
    VERD_ACK_OK       = 4'd6,
    VERD_BAD_ACK_COPY = 4'd7,
    VERD_BAD_TYPE     = 4'd8,
    VERD_SHORT_PART   = 4'd9
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  payload_byte;
    verdict_t    verdict;
    logic [15:0] frame_sequence;
    logic        ack_request;
    logic        joins_held_part;
  } out_item_t;

endpackage

>>> rtl/gbnfr_in_stage.sv
// ----------------------------------------------------------------------------
// gbnfr_in_stage
// Input register holding one received byte transaction for the frame core.
// ----------------------------------------------------------------------------
module gbnfr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbnfr_pkg::in_item_t in_item,
  input  logic                advance,
  output logic                stage_valid,
  output gbnfr_pkg::in_item_t stage_item
);

  logic                valid_r;
  logic                valid_nxt;
  gbnfr_pkg::in_item_t item_r;
  logic                take;

  assign in_ready    = !valid_r || advance;
  assign take        = in_valid && in_ready;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/gbnfr_core.sv
// ----------------------------------------------------------------------------
// gbnfr_core
// Frame parser, running check word, payload delay and end-of-frame judgment.
// ----------------------------------------------------------------------------
module gbnfr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  gbnfr_pkg::in_item_t  step_item,
  output logic                 res_valid,
  output gbnfr_pkg::out_item_t res_item
);

  logic [gbnfr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                  type_r, type_nxt;
  logic [15:0]                 seq_r, seq_nxt;
  logic [7:0]                  end_r, end_nxt;
  logic [15:0]                 acc_r, acc_nxt;
  logic [7:0]                  pend_r, pend_nxt;
  logic [7:0]                  dly0_r, dly0_nxt;
  logic [7:0]                  dly1_r, dly1_nxt;
  logic [15:0]                 exp_r, exp_nxt;
  logic                        held_r, held_nxt;

  logic [7:0]          b;
  logic [15:0]         acc_fin;
  logic [15:0]         rx_check;
  logic [15:0]         seq_gap;
  gbnfr_pkg::verdict_t verd;
  logic                ack;
  logic                joins;

  always_comb begin
    pos_nxt   = pos_r;
    type_nxt  = type_r;
    seq_nxt   = seq_r;
    end_nxt   = end_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    exp_nxt   = exp_r;
    held_nxt  = held_r;
    b         = step_item.rx_byte;
    acc_fin   = acc_r;
    rx_check  = {dly0_r, step_item.rx_byte};
    seq_gap   = '0;
    verd      = gbnfr_pkg::VERD_PACKET_DONE;
    ack       = 1'b0;
    joins     = 1'b0;
    res_valid = 1'b0;
    res_item  = '0;

    if (step_en) begin
      // header capture
      case (pos_r)
        '0: begin
          type_nxt = b;
          seq_nxt  = '0;
          end_nxt  = '0;
          acc_nxt  = '0;
          pend_nxt = '0;
        end
        gbnfr_pkg::POS_SEQ_HI: begin
          seq_nxt = {b, 8'h00};
        end
        gbnfr_pkg::POS_SEQ_LO: begin
          seq_nxt = {seq_r[15:8], b};
        end
        gbnfr_pkg::POS_END_MARK: begin
          end_nxt = b;
        end
        gbnfr_pkg::POS_ACK_COPY_LO: begin
          if (type_r != gbnfr_pkg::TYPE_DATA) begin
            pend_nxt = b;
          end
        end
        default: begin
        end
      endcase

      // byte two back is now known to be covered by the check word
      if (type_nxt == gbnfr_pkg::TYPE_DATA && pos_r >= gbnfr_pkg::POS_SEQ_LO) begin
        if (!pos_r[0]) begin
          pend_nxt = dly1_r;
        end else begin
          acc_nxt = acc_nxt ^ {dly1_r, pend_nxt};
        end
      end

      dly1_nxt = dly0_r;
      dly0_nxt = b;

      if (!step_item.last_byte) begin
        if (type_nxt == gbnfr_pkg::TYPE_DATA && pos_r >= gbnfr_pkg::POS_FIRST_PAY &&
            pos_r <= gbnfr_pkg::POS_STREAM_LAST) begin
          res_valid             = 1'b1;
          res_item.item_kind    = gbnfr_pkg::KIND_PAYLOAD;
          res_item.payload_byte = dly0_r;
        end
        pos_nxt = (pos_r == gbnfr_pkg::POS_SAT) ? pos_r : pos_r + 7'd1;
      end else begin
        // odd final byte lands in the low half
        acc_fin = acc_nxt;
        if (type_nxt == gbnfr_pkg::TYPE_DATA && pos_r >= gbnfr_pkg::POS_SEQ_LO && !pos_r[0]) begin
          acc_fin = acc_nxt ^ {8'h00, pend_nxt};
        end
        seq_gap = exp_r - seq_nxt;

        if (pos_r < gbnfr_pkg::POS_ACK_COPY_LO || pos_r > gbnfr_pkg::POS_MAX_LAST) begin
          verd = gbnfr_pkg::VERD_BAD_LENGTH;
        end else if (type_nxt == gbnfr_pkg::TYPE_DATA) begin
          if (pos_r < gbnfr_pkg::POS_FIRST_PAY) begin
            verd = gbnfr_pkg::VERD_BAD_LENGTH;
          end else if (acc_fin != rx_check) begin
            verd = gbnfr_pkg::VERD_BAD_CHECK;
          end else if (seq_nxt != exp_r) begin
            if (seq_gap != 16'd0 && seq_gap <= gbnfr_pkg::WINDOW_HI) begin
              ack  = 1'b1;
              verd = gbnfr_pkg::VERD_DUPLICATE;
            end else begin
              verd = gbnfr_pkg::VERD_OUT_OF_WIN;
            end
          end else begin
            exp_nxt = exp_r + 16'd1;
            ack     = 1'b1;
            if (end_nxt != gbnfr_pkg::END_OF_PACKET) begin
              if (pos_r != gbnfr_pkg::POS_MAX_LAST) begin
                verd = gbnfr_pkg::VERD_SHORT_PART;
              end else begin
                held_nxt = 1'b1;
                verd     = gbnfr_pkg::VERD_FIRST_HELD;
              end
            end else begin
              joins    = held_r;
              held_nxt = 1'b0;
              verd     = gbnfr_pkg::VERD_PACKET_DONE;
            end
          end
        end else if (type_nxt == gbnfr_pkg::TYPE_ACK) begin
          if (end_nxt == seq_nxt[15:8] && pend_nxt == seq_nxt[7:0]) begin
            verd = gbnfr_pkg::VERD_ACK_OK;
          end else begin
            verd = gbnfr_pkg::VERD_BAD_ACK_COPY;
          end
        end else begin
          verd = gbnfr_pkg::VERD_BAD_TYPE;
        end

        res_valid                = 1'b1;
        res_item.item_kind       = gbnfr_pkg::KIND_VERDICT;
        res_item.verdict         = verd;
        res_item.frame_sequence  = seq_nxt;
        res_item.ack_request     = ack;
        res_item.joins_held_part = joins;

        // frame registers start over
        pos_nxt  = '0;
        type_nxt = '0;
        seq_nxt  = '0;
        end_nxt  = '0;
        acc_nxt  = '0;
        pend_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      type_r <= '0;
      seq_r  <= '0;
      end_r  <= '0;
      acc_r  <= '0;
      pend_r <= '0;
      dly0_r <= '0;
      dly1_r <= '0;
      exp_r  <= '0;
      held_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      seq_r  <= seq_nxt;
      end_r  <= end_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      dly0_r <= dly0_nxt;
      dly1_r <= dly1_nxt;
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

>>> rtl/gbnfr_out_stage.sv
// ----------------------------------------------------------------------------
// gbnfr_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module gbnfr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  gbnfr_pkg::out_item_t res_item,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gbnfr_pkg::out_item_t out_item
);

  logic                 valid_r;
  logic                 valid_nxt;
  gbnfr_pkg::out_item_t item_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = advance ? res_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      item_r <= res_item;
    end
  end

endmodule

>>> rtl/gbn_frame_receiver_top.sv
// path: input register, combinational frame core, then the result register on out_valid
// throughput: one frame byte per cycle unless stalled, limited by the single core pass
// a byte yields at most one result; a stalled output holds the core and then the input
// reset: synchronous active-low rst_n clears both stage valids and all frame state
// ----------------------------------------------------------------------------
// gbn_frame_receiver_top
// Go-back-n frame receiver: streams payload bytes and gives a per-frame verdict.
// ----------------------------------------------------------------------------
module gbn_frame_receiver_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbnfr_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gbnfr_pkg::out_item_t out_item
);

  logic                 advance;
  logic                 stage_valid;
  gbnfr_pkg::in_item_t  stage_item;
  logic                 res_valid;
  gbnfr_pkg::out_item_t res_item;
  logic                 step_en;

  assign step_en = stage_valid && advance;

  gbnfr_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  gbnfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_item (stage_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  gbnfr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
